@@ rtl/core/matrix_checksum_encoder_unit_macros.svh @@
// Assertion macros shared by the checksum encoder RTL.
`ifndef MATRIX_CHECKSUM_ENCODER_UNIT_MACROS_SVH
`define MATRIX_CHECKSUM_ENCODER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MCE_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("checksum encoder: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define MCE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("checksum encoder: next-cycle check failed");

`endif

@@ rtl/core/mce_pkg.sv @@
// Shared types, constants and arithmetic for the checksum encoder.
package mce_pkg;

    // Default and limits for the column storage.
    localparam int MAX_COLS_DEF = 32;

    // Field widths.
    localparam int ELEM_W  = 32;
    localparam int SUM_W   = 48;
    localparam int ROWS_W  = 16;
    localparam int COLS_W  = 6;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    // Register addresses (index bit of paddr).
    localparam logic REG_ROW_COUNT    = 1'b0;
    localparam logic REG_COLUMN_COUNT = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [ROWS_W-1:0] ROW_COUNT_RST    = 16'd4;
    localparam logic [COLS_W-1:0] COLUMN_COUNT_RST = 6'd4;

    // Kind of each output word.
    typedef enum logic [1:0] {
        KIND_ELEM   = 2'd0,
        KIND_ROW    = 2'd1,
        KIND_COL    = 2'd2,
        KIND_CORNER = 2'd3
    } word_kind_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ELEM,
        ST_ROW,
        ST_COL,
        ST_CORNER
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic elem_load;
        logic row_load;
        logic col_load;
        logic corner_load;
        logic sel_col;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic row_end;
        logic mat_end;
        logic col_done;
    } dp_status_t;

    // Saturating add of two 48-bit signed sums.
    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0] a,
        input logic signed [SUM_W-1:0] b
    );
        logic signed [SUM_W:0] s;
        logic signed [SUM_W-1:0] r;
        s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
        if (s[SUM_W] != s[SUM_W-1]) begin
            r = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            r = s[SUM_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/core/mce_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module mce_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/mce_ctrl.sv @@
// Controller state machine that sequences element, row-sum, column-sum and corner words.
module mce_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mce_pkg::dp_status_t status,
    output mce_pkg::ctrl_cmd_t  cmd
);
    import mce_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid) begin
                    state_next = ST_ELEM;
                end
            end
            ST_ELEM: begin
                if (status.out_free) begin
                    cmd.elem_load = 1'b1;
                    state_next    = status.row_end ? ST_ROW : ST_IDLE;
                end
            end
            ST_ROW: begin
                cmd.sel_col = 1'b1;
                if (status.out_free) begin
                    cmd.row_load = 1'b1;
                    state_next   = status.mat_end ? ST_COL : ST_IDLE;
                end
            end
            ST_COL: begin
                cmd.sel_col = 1'b1;
                if (status.out_free) begin
                    cmd.col_load = 1'b1;
                    if (status.col_done) begin
                        state_next = ST_CORNER;
                    end
                end
            end
            ST_CORNER: begin
                if (status.out_free) begin
                    cmd.corner_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/mce_datapath.sv @@
// Datapath: accumulators, positions, column store and output register.
module mce_datapath #(
    parameter int MAX_COLS = mce_pkg::MAX_COLS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  mce_pkg::ctrl_cmd_t                 cmd,
    output mce_pkg::dp_status_t                status,
    input  logic signed [mce_pkg::ELEM_W-1:0]  s_element,
    input  logic [mce_pkg::COLS_W-1:0]         cols_eff,
    input  logic [mce_pkg::ROWS_W-1:0]         rows_eff,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [mce_pkg::SUM_W-1:0]   m_value,
    output logic [1:0]                         m_word_kind,
    output logic                               m_run_last
);
    import mce_pkg::*;

    localparam int IDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    logic signed [ELEM_W-1:0] elem_reg;
    logic signed [SUM_W-1:0]  row_acc_reg;
    logic [COLS_W-1:0]        col_pos_reg;
    logic [ROWS_W-1:0]        row_pos_reg;
    logic [COLS_W-1:0]        col_cnt_reg;
    logic [MAX_COLS-1:0]      col_valid_reg;

    logic                     m_valid_reg;
    logic signed [SUM_W-1:0]  m_value_reg;
    word_kind_t               m_kind_reg;
    logic                     m_last_reg;

    logic [COLS_W-1:0]        pos_inc;
    logic [ROWS_W-1:0]        row_inc;
    logic [COLS_W-1:0]        cnt_inc;
    logic [IDX_W-1:0]         pos_idx;
    logic [IDX_W-1:0]         cnt_idx;
    logic [IDX_W-1:0]         rd_addr;
    logic [SUM_W-1:0]         rd_data;
    logic signed [SUM_W-1:0]  elem_ext;
    logic signed [SUM_W-1:0]  col_old;
    logic signed [SUM_W-1:0]  col_sum;
    logic signed [SUM_W-1:0]  row_sum;
    logic signed [SUM_W-1:0]  col_out;
    logic                     col_we;

    // Position arithmetic and end-of-row, end-of-matrix tests.
    assign pos_inc = col_pos_reg + COLS_W'(1);
    assign row_inc = row_pos_reg + ROWS_W'(1);
    assign cnt_inc = col_cnt_reg + COLS_W'(1);
    assign pos_idx = col_pos_reg[IDX_W-1:0];
    assign cnt_idx = col_cnt_reg[IDX_W-1:0];

    assign status.out_free = !m_valid_reg || m_ready;
    assign status.row_end  = (pos_inc >= cols_eff) || (pos_inc == '0);
    assign status.mat_end  = (row_inc >= rows_eff) || (row_inc == '0);
    assign status.col_done = (cnt_inc >= cols_eff);

    // Read address: column walk when emitting sums, else the current column.
    always_comb begin
        if (cmd.sel_col) begin
            rd_addr = cmd.col_load ? cnt_inc[IDX_W-1:0] : cnt_idx;
        end else begin
            rd_addr = pos_idx;
        end
    end

    // Sums; an entry never written since the last clear reads as zero.
    assign elem_ext = {{(SUM_W-ELEM_W){elem_reg[ELEM_W-1]}}, elem_reg};
    assign col_old  = col_valid_reg[pos_idx] ? $signed(rd_data) : '0;
    assign col_sum  = sat_add(col_old, elem_ext);
    assign row_sum  = sat_add(row_acc_reg, elem_ext);
    assign col_out  = col_valid_reg[cnt_idx] ? $signed(rd_data) : '0;
    assign col_we   = cmd.elem_load && (col_pos_reg < COLS_W'(MAX_COLS));

    mce_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_COLS)
    ) u_col_ram (
        .aclk  (aclk),
        .we    (col_we),
        .waddr (pos_idx),
        .wdata (col_sum),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Element capture.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            elem_reg <= s_element;
        end
    end

    // Accumulator, positions and column valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_acc_reg   <= '0;
            col_pos_reg   <= '0;
            row_pos_reg   <= '0;
            col_cnt_reg   <= '0;
            col_valid_reg <= '0;
        end else begin
            if (cmd.elem_load) begin
                row_acc_reg <= row_sum;
                col_pos_reg <= pos_inc;
                if (col_we) begin
                    col_valid_reg[pos_idx] <= 1'b1;
                end
            end
            if (cmd.row_load) begin
                row_acc_reg <= '0;
                col_pos_reg <= '0;
                row_pos_reg <= status.mat_end ? '0 : row_inc;
            end
            if (cmd.col_load) begin
                col_cnt_reg <= cnt_inc;
            end
            if (cmd.corner_load) begin
                col_cnt_reg   <= '0;
                col_valid_reg <= '0;
            end
        end
    end

    // Output valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.elem_load || cmd.row_load || cmd.col_load || cmd.corner_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge aclk) begin
        if (cmd.elem_load) begin
            m_value_reg <= elem_ext;
            m_kind_reg  <= KIND_ELEM;
            m_last_reg  <= !status.row_end;
        end else if (cmd.row_load) begin
            m_value_reg <= row_acc_reg;
            m_kind_reg  <= KIND_ROW;
            m_last_reg  <= !status.mat_end;
        end else if (cmd.col_load) begin
            m_value_reg <= col_out;
            m_kind_reg  <= KIND_COL;
            m_last_reg  <= 1'b0;
        end else if (cmd.corner_load) begin
            m_value_reg <= '0;
            m_kind_reg  <= KIND_CORNER;
            m_last_reg  <= 1'b1;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_value     = m_value_reg;
    assign m_word_kind = m_kind_reg;
    assign m_run_last  = m_last_reg;

endmodule

@@ rtl/core/matrix_checksum_encoder_unit.sv @@
// Top level of the row and column checksum matrix encoder.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_valid/s_ready    s_element (Q16.16)
//   m_        out        m_valid/m_ready    m_value (Q32.16), m_word_kind, m_run_last
//   APB       in         psel/penable       paddr, pwdata, prdata (row_count, column_count)
//
// Each item is accepted, then the column store is read and updated; the row
// sum adds a row-sum word, and the last row adds one column-sum word per column plus the
// corner word, all walked by the controller through the column RAM's single read port.
// Reset is synchronous and active low; no clearing pass.
// A stalled m_ready holds the controller in its current word state.
module matrix_checksum_encoder_unit #(
    parameter int MAX_COLS = mce_pkg::MAX_COLS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [mce_pkg::ELEM_W-1:0]  s_element,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [mce_pkg::SUM_W-1:0]   m_value,
    output logic [1:0]                         m_word_kind,
    output logic                               m_run_last,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mce_pkg::APB_AW-1:0]         paddr,
    input  logic [mce_pkg::APB_DW-1:0]         pwdata,
    output logic [mce_pkg::APB_DW-1:0]         prdata,
    output logic                               pready
);
    import mce_pkg::*;

    `include "matrix_checksum_encoder_unit_macros.svh"

    logic [ROWS_W-1:0] row_count_reg;
    logic [COLS_W-1:0] column_count_reg;
    logic [ROWS_W-1:0] rows_eff;
    logic [COLS_W-1:0] cols_eff;
    logic              cfg_write;
    ctrl_cmd_t         cmd;
    dp_status_t        status;

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg    <= ROW_COUNT_RST;
            column_count_reg <= COLUMN_COUNT_RST;
        end else if (cfg_write) begin
            if (paddr[2] == REG_ROW_COUNT) begin
                row_count_reg <= pwdata[ROWS_W-1:0];
            end else begin
                column_count_reg <= pwdata[COLS_W-1:0];
            end
        end
    end

    // Register readback.
    assign prdata = (paddr[2] == REG_COLUMN_COUNT) ?
                    {{(APB_DW-COLS_W){1'b0}}, column_count_reg} :
                    {{(APB_DW-ROWS_W){1'b0}}, row_count_reg};

    // Effective counts: zero acts as one, columns clamp to the store depth.
    assign rows_eff = (row_count_reg == '0) ? ROWS_W'(1) : row_count_reg;
    always_comb begin
        if (column_count_reg == '0) begin
            cols_eff = COLS_W'(1);
        end else if (column_count_reg > COLS_W'(MAX_COLS)) begin
            cols_eff = COLS_W'(MAX_COLS);
        end else begin
            cols_eff = column_count_reg;
        end
    end

    mce_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mce_datapath #(
        .MAX_COLS (MAX_COLS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .s_element   (s_element),
        .cols_eff    (cols_eff),
        .rows_eff    (rows_eff),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value     (m_value),
        .m_word_kind (m_word_kind),
        .m_run_last  (m_run_last)
    );

    // One item at a time: no new item is taken the cycle after an accept.
    `MCE_ASSERT_NEXT(a_one_item, aclk, aresetn, s_valid && s_ready, !s_ready)
    // The corner word is zero and always closes its item.
    `MCE_ASSERT_IMPL(a_corner_word, aclk, aresetn, m_valid && (m_word_kind == KIND_CORNER), (m_value == '0) && m_run_last)
    // A column sum never closes an item.
    `MCE_ASSERT_IMPL(a_col_not_last, aclk, aresetn, m_valid && (m_word_kind == KIND_COL), !m_run_last)

endmodule

@@ sim/checksum_matrix_checker.sv @@
// Checker that follows the encoder's configuration, predicts its output words and compares them.
`timescale 1ns / 100ps

module checksum_matrix_checker #(
    parameter int MAX_COLS = mce_pkg::MAX_COLS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  logic signed [mce_pkg::ELEM_W-1:0]  s_element,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic signed [mce_pkg::SUM_W-1:0]   m_value,
    input  logic [1:0]                         m_word_kind,
    input  logic                               m_run_last,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic                               pready,
    input  logic [mce_pkg::APB_AW-1:0]         paddr,
    input  logic [mce_pkg::APB_DW-1:0]         pwdata,
    output int                                 mismatch_count,
    output int                                 words_pending
);
    import mce_pkg::*;

    // Limits of a 48-bit signed sum, held one bit wider for the overflow test.
    localparam logic signed [SUM_W:0] SUM_TOP    = (49'sd1 <<< (SUM_W - 1)) - 49'sd1;
    localparam logic signed [SUM_W:0] SUM_BOTTOM = -(49'sd1 <<< (SUM_W - 1));

    // One expected output word.
    typedef struct {
        logic signed [SUM_W-1:0] value;
        word_kind_t              kind;
        logic                    last;
    } coded_word_t;

    coded_word_t expected_words[$];

    // Shadow of the configuration registers and of the encoder's running state.
    logic [ROWS_W-1:0]       shape_rows;
    logic [COLS_W-1:0]       shape_cols;
    logic signed [SUM_W-1:0] row_sum;
    logic signed [SUM_W-1:0] col_sums [MAX_COLS];
    logic [COLS_W-1:0]       col_pos;
    logic [ROWS_W-1:0]       row_pos;

    // Adds two sums and clamps the result to the 48-bit range.
    function automatic logic signed [SUM_W-1:0] clamp_add(
        input logic signed [SUM_W-1:0] acc,
        input logic signed [SUM_W-1:0] addend
    );
        logic signed [SUM_W:0] wide;
        logic signed [SUM_W-1:0] result;
        wide = acc + addend;
        if (wide > SUM_TOP) begin
            result = SUM_TOP[SUM_W-1:0];
        end else if (wide < SUM_BOTTOM) begin
            result = SUM_BOTTOM[SUM_W-1:0];
        end else begin
            result = wide[SUM_W-1:0];
        end
        return result;
    endfunction

    task automatic push_word(
        input logic signed [SUM_W-1:0] value,
        input word_kind_t              kind,
        input logic                    last
    );
        coded_word_t w;
        w.value = value;
        w.kind  = kind;
        w.last  = last;
        expected_words.insert(expected_words.size(), w);
    endtask

    task automatic clear_columns();
        for (int c = 0; c < MAX_COLS; c++) begin
            col_sums[c] = '0;
        end
    endtask

    // Works out the words that one element causes and advances the shadow state.
    task automatic encode_element(input logic signed [ELEM_W-1:0] elem);
        int                      eff_cols;
        int                      eff_rows;
        logic signed [SUM_W-1:0] elem_wide;
        logic [COLS_W-1:0]       next_col;
        logic [ROWS_W-1:0]       next_row;
        logic                    row_done;
        logic                    matrix_done;
        // A zero count acts as one, and columns are capped at the storage size.
        if (shape_cols == 0) begin
            eff_cols = 1;
        end else if (shape_cols > MAX_COLS) begin
            eff_cols = MAX_COLS;
        end else begin
            eff_cols = int'(shape_cols);
        end
        eff_rows = (shape_rows == 0) ? 1 : int'(shape_rows);
        elem_wide = elem;
        next_col = col_pos + 1'b1;
        next_row = row_pos + 1'b1;
        // A position that has reached or passed the count ends the row or the matrix.
        row_done = (next_col >= eff_cols) || (next_col == 0);
        matrix_done = row_done && ((next_row >= eff_rows) || (next_row == 0));

        push_word(elem_wide, KIND_ELEM, !row_done);
        row_sum = clamp_add(row_sum, elem_wide);
        if (col_pos < MAX_COLS) begin
            col_sums[col_pos] = clamp_add(col_sums[col_pos], elem_wide);
        end
        col_pos = next_col;

        if (row_done) begin
            push_word(row_sum, KIND_ROW, !matrix_done);
            row_sum = '0;
            col_pos = '0;
            row_pos = next_row;
            if (matrix_done) begin
                for (int c = 0; c < eff_cols; c++) begin
                    push_word(col_sums[c], KIND_COL, 1'b0);
                end
                push_word('0, KIND_CORNER, 1'b1);
                clear_columns();
                row_pos = '0;
            end
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("%0t: checksum encoder mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // Compares one accepted output word with the oldest expected word.
    task automatic check_word();
        coded_word_t want;
        if (expected_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word value %0d kind %0d last %0b",
                m_value, m_word_kind, m_run_last));
        end else begin
            want = expected_words.pop_front();
            if (m_value !== want.value) begin
                report_mismatch($sformatf("value %0d, expected %0d (kind %0d)",
                    m_value, want.value, want.kind));
            end
            if (m_word_kind !== want.kind) begin
                report_mismatch($sformatf("word kind %0d, expected %0d",
                    m_word_kind, want.kind));
            end
            if (m_run_last !== want.last) begin
                report_mismatch($sformatf("run_last %0b, expected %0b (kind %0d)",
                    m_run_last, want.last, want.kind));
            end
        end
    endtask

    // Watch the configuration port and both channels at every rising edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            shape_rows = ROW_COUNT_RST;
            shape_cols = COLUMN_COUNT_RST;
            row_sum = '0;
            col_pos = '0;
            row_pos = '0;
            clear_columns();
            expected_words.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[APB_AW-1] == REG_COLUMN_COUNT) begin
                    shape_cols = pwdata[COLS_W-1:0];
                end else begin
                    shape_rows = pwdata[ROWS_W-1:0];
                end
            end
            if (s_valid && s_ready) begin
                encode_element(s_element);
            end
            if (m_valid && m_ready) begin
                check_word();
            end
        end
        words_pending <= expected_words.size();
    end

endmodule

@@ sim/tb.sv @@
// Testbench top: drives the checksum encoder's channels and configuration port and gives the verdict.
`timescale 1ns / 100ps

module tb;
    import mce_pkg::*;

    localparam int RANDOM_ITEMS = 300;
    localparam int QUIET_AFTER  = 250;
    localparam int HOLD_AT      = 60;
    localparam int LONG_HOLD    = 300;

    localparam logic [ELEM_W-1:0] ELEM_MAX = 32'h7FFF_FFFF;
    localparam logic [ELEM_W-1:0] ELEM_MIN = 32'h8000_0000;

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic signed [ELEM_W-1:0]   s_element;
    logic                       m_valid;
    logic                       m_ready;
    logic signed [SUM_W-1:0]    m_value;
    logic [1:0]                 m_word_kind;
    logic                       m_run_last;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [APB_AW-1:0]          paddr;
    logic [APB_DW-1:0]          pwdata;
    logic [APB_DW-1:0]          prdata;
    logic                       pready;

    int   mismatch_count;
    int   words_pending;
    int   random_sent;
    logic quiet;
    logic hold_request;
    logic hold_served = 1'b0;

    matrix_checksum_encoder_unit #(
        .MAX_COLS (MAX_COLS_DEF)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_element   (s_element),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value     (m_value),
        .m_word_kind (m_word_kind),
        .m_run_last  (m_run_last),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    checksum_matrix_checker #(
        .MAX_COLS (MAX_COLS_DEF)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_element      (s_element),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_value        (m_value),
        .m_word_kind    (m_word_kind),
        .m_run_last     (m_run_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .mismatch_count (mismatch_count),
        .words_pending  (words_pending)
    );

    // 50 MHz clock.
    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // Guard time, far beyond the slowest correct run.
    initial begin
        #20_000_000;
        $display("FAIL matrix_checksum_encoder_unit");
        $finish;
    end

    // Output side: random stall bursts, one long hold-off on request, none at the end.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request && !hold_served) begin
                hold_served = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(0, 8)) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic logic [ELEM_W-1:0] random_element();
        logic [ELEM_W-1:0] elem;
        case ($urandom_range(0, 15))
            0:       elem = ELEM_MAX;
            1:       elem = ELEM_MIN;
            2:       elem = '0;
            3:       elem = '1;
            4:       elem = $urandom_range(0, 255);
            default: elem = $urandom();
        endcase
        return elem;
    endfunction

    // Register write: setup, then access.
    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Sets the matrix shape; the upper data bits carry noise that must be dropped.
    task automatic write_shape(input logic [ROWS_W-1:0] rows, input logic [COLS_W-1:0] cols);
        apb_write({REG_ROW_COUNT, 2'b00}, ($urandom() & 32'hFFFF_0000) | rows);
        apb_write({REG_COLUMN_COUNT, 2'b00}, ($urandom() & 32'hFFFF_FFC0) | cols);
    endtask

    // Offers one item, after a random gap now and then, and waits until it is taken.
    task automatic send_element(input logic [ELEM_W-1:0] elem);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 9);
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_element <= elem;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stops offering items and waits until every expected word has come out.
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        do @(posedge aclk); while (words_pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        logic [ROWS_W-1:0] rows;
        logic [COLS_W-1:0] cols;
        int                eff_rows;
        int                eff_cols;
        int                count;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_element = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        quiet = 1'b0;
        hold_request = 1'b0;
        random_sent = 0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // Single-element matrices with the element extremes.
        write_shape(16'd1, 6'd1);
        send_element(ELEM_MAX);
        send_element(ELEM_MIN);
        wait_drained();

        // Zero row and column counts act as one.
        write_shape(16'd0, 6'd0);
        send_element('0);
        send_element('1);
        wait_drained();

        // Two by two with full-scale elements of both signs.
        write_shape(16'd2, 6'd2);
        send_element(ELEM_MAX);
        send_element(ELEM_MAX);
        send_element(ELEM_MIN);
        send_element(ELEM_MIN);
        wait_drained();

        // Tallest matrix, ended early by lowering the row count below the position.
        write_shape(16'hFFFF, 6'd2);
        repeat (4) send_element(random_element());
        wait_drained();
        write_shape(16'd1, 6'd2);
        repeat (2) send_element(random_element());
        wait_drained();

        // Column count lowered mid-row below the column position.
        write_shape(16'd1, 6'd5);
        repeat (3) send_element(random_element());
        wait_drained();
        write_shape(16'd1, 6'd2);
        send_element(random_element());
        wait_drained();

        // Random shapes: mostly whole matrices, sometimes partial rows or matrices.
        while (random_sent < RANDOM_ITEMS) begin
            if (!hold_request && random_sent >= HOLD_AT) begin
                // A full 8 by 8 matrix while the output side holds off for a long time.
                rows = 16'd8;
                cols = 6'd8;
                count = 64;
            end else begin
                case ($urandom_range(0, 9))
                    0:       rows = 16'd0;
                    1:       rows = 16'hFFFF;
                    2:       rows = ROWS_W'($urandom_range(5, 16));
                    default: rows = ROWS_W'($urandom_range(1, 4));
                endcase
                case ($urandom_range(0, 9))
                    0:       cols = 6'd0;
                    1:       cols = COLS_W'(MAX_COLS_DEF);
                    2:       cols = COLS_W'($urandom_range(MAX_COLS_DEF + 1, 63));
                    3:       cols = COLS_W'($urandom_range(9, MAX_COLS_DEF - 1));
                    default: cols = COLS_W'($urandom_range(1, 8));
                endcase
                eff_rows = (rows == 0) ? 1 : int'(rows);
                if (cols == 0) begin
                    eff_cols = 1;
                end else if (cols > MAX_COLS_DEF) begin
                    eff_cols = MAX_COLS_DEF;
                end else begin
                    eff_cols = int'(cols);
                end
                if ($urandom_range(0, 3) != 0) begin
                    count = (eff_rows * eff_cols <= 64) ? eff_rows * eff_cols
                                                        : eff_cols * $urandom_range(1, 2);
                end else begin
                    count = $urandom_range(1, 2 * eff_cols + 3);
                end
            end
            write_shape(rows, cols);
            if (!hold_request && rows == 16'd8 && count == 64 && random_sent >= HOLD_AT) begin
                hold_request <= 1'b1;
            end
            repeat (count) begin
                send_element(random_element());
                random_sent++;
                if (random_sent == QUIET_AFTER) begin
                    quiet <= 1'b1;
                end
            end
            wait_drained();
        end

        repeat (40) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("PASS matrix_checksum_encoder_unit");
        end else begin
            $display("FAIL matrix_checksum_encoder_unit");
        end
        $finish;
    end

endmodule
